// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

	// operation codes of a request
	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;
	localparam logic [2:0] OP_DROP_UNTIL = 3'd5;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] item_value;
	} deq_cmd_t;

	typedef struct packed {
		logic [31:0] popped_value;
		logic        popped_valid;
		logic        queue_empty;
		logic [4:0]  entry_count;
		logic        overflow;
	} deq_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_HOLD
	} deq_state_t;

endpackage

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
// channel   signals                      direction
// cmd       cmd_valid, cmd_stall, cmd    request in (operation, item_value)
// rsp       rsp_valid, rsp_stall, rsp    one result out per request
//
// push, clear, unused codes, and pops or drop until of an empty queue answer from idle;
// pops of a non-empty queue read the ram and answer from the pop state.
// drop until scans entries from the front in the scan state (at most DEPTH): one ram read a cycle.
// arst_n empties the queue; ram contents are not cleared, only written entries are read.
// a result waiting on rsp_stall sits in the output register; a second one waits in a
// hold register and cmd_stall stays high until it moves out.

module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  deq_pkg::deq_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output deq_pkg::deq_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	deq_pkg::deq_state_t state_q, state_d;

	logic [AW-1:0]         front_q, front_d;
	logic [CW-1:0]         count_q, count_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	logic                  single_q, single_d;
	deq_pkg::deq_rsp_t     hold_q, hold_d;
	deq_pkg::deq_rsp_t     out_q, out_d;
	logic                  out_valid_q, out_valid_d;

	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_rdata;

	logic [DATA_WIDTH-1:0] cmd_val;
	logic [31:0]           rd_val32;
	logic [4:0]            count5;

	logic                  res_fire;
	logic                  res_popped;
	logic                  res_ovf;
	deq_pkg::deq_rsp_t     res_d;
	logic                  out_free;

	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(p) + (CW+1)'(off);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	generate
		if (DATA_WIDTH <= 32) begin : g_val_narrow
			assign cmd_val = cmd.item_value[DATA_WIDTH-1:0];
		end else begin : g_val_wide
			assign cmd_val = {{(DATA_WIDTH-32){1'b0}}, cmd.item_value};
		end
		if (DATA_WIDTH >= 32) begin : g_rd_wide
			assign rd_val32 = mem_rdata[31:0];
		end else begin : g_rd_narrow
			assign rd_val32 = {{(32-DATA_WIDTH){1'b0}}, mem_rdata};
		end
		if (CW >= 5) begin : g_cnt_wide
			assign count5 = count_d[4:0];
		end else begin : g_cnt_narrow
			assign count5 = {{(5-CW){1'b0}}, count_d};
		end
	endgenerate

	deq_ram #(
		.DEPTH(DEPTH),
		.WIDTH(DATA_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(cmd_val),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		front_d    = front_q;
		count_d    = count_q;
		val_d      = val_q;
		single_d   = single_q;
		mem_we     = 1'b0;
		mem_waddr  = front_q;
		mem_re     = 1'b0;
		mem_raddr  = front_q;
		res_fire   = 1'b0;
		res_popped = 1'b0;
		res_ovf    = 1'b0;
		cmd_stall  = 1'b1;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					res_fire = 1'b1;
					unique case (cmd.operation)
						deq_pkg::OP_PUSH_BACK: begin
							if (count_q == CW'(DEPTH)) begin
								res_ovf = 1'b1;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = ptr_add(front_q, count_q);
								count_d   = count_q + CW'(1);
							end
						end
						deq_pkg::OP_PUSH_FRONT: begin
							if (count_q == CW'(DEPTH)) begin
								res_ovf = 1'b1;
							end else begin
								front_d   = ptr_dec(front_q);
								mem_we    = 1'b1;
								mem_waddr = ptr_dec(front_q);
								count_d   = count_q + CW'(1);
							end
						end
						deq_pkg::OP_POP_FRONT: begin
							if (count_q != '0) begin
								mem_re    = 1'b1;
								mem_raddr = front_q;
								front_d   = ptr_inc(front_q);
								count_d   = count_q - CW'(1);
								res_fire  = 1'b0;
							end
						end
						deq_pkg::OP_POP_BACK: begin
							if (count_q != '0) begin
								mem_re    = 1'b1;
								mem_raddr = ptr_add(front_q, count_q - CW'(1));
								count_d   = count_q - CW'(1);
								res_fire  = 1'b0;
							end
						end
						deq_pkg::OP_CLEAR: begin
							front_d = '0;
							count_d = '0;
						end
						deq_pkg::OP_DROP_UNTIL: begin
							if (count_q != '0) begin
								mem_re    = 1'b1;
								mem_raddr = front_q;
								val_d     = cmd_val;
								single_d  = (count_q == CW'(1));
								res_fire  = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			deq_pkg::ST_POP: begin
				res_fire   = 1'b1;
				res_popped = 1'b1;
			end
			deq_pkg::ST_SCAN: begin
				// ram data holds the entry at front_q
				if (mem_rdata == val_q) begin
					res_fire = 1'b1;
					if (single_q) begin
						count_d = '0;
					end
				end else if (single_q) begin
					res_fire = 1'b1;
				end else begin
					front_d = ptr_inc(front_q);
					count_d = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						res_fire = 1'b1;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = ptr_inc(front_q);
					end
				end
			end
			deq_pkg::ST_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	assign res_d.popped_value = res_popped ? rd_val32 : 32'd0;
	assign res_d.popped_valid = res_popped;
	assign res_d.queue_empty  = (count_d == '0);
	assign res_d.entry_count  = count5;
	assign res_d.overflow     = res_ovf;

	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		state_d     = state_q;
		hold_d      = hold_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && rsp_stall;
		if (state_q == deq_pkg::ST_HOLD) begin
			if (out_free) begin
				out_d       = hold_q;
				out_valid_d = 1'b1;
				state_d     = deq_pkg::ST_IDLE;
			end
		end else if (res_fire) begin
			if (out_free) begin
				out_d       = res_d;
				out_valid_d = 1'b1;
				state_d     = deq_pkg::ST_IDLE;
			end else begin
				hold_d  = res_d;
				state_d = deq_pkg::ST_HOLD;
			end
		end else if (state_q == deq_pkg::ST_IDLE && cmd_valid) begin
			// pops and drop until wait on the ram read
			state_d = (cmd.operation == deq_pkg::OP_DROP_UNTIL) ? deq_pkg::ST_SCAN
			                                                    : deq_pkg::ST_POP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			single_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_q     <= front_d;
			count_q     <= count_d;
			single_q    <= single_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q  <= val_d;
		hold_q <= hold_d;
		out_q  <= out_d;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: rtl/core/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
